// ===== sv/awq_pkg.sv =====
package awq_pkg;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Event codes of a result.
    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_START_HIGH = 2'd1;
    localparam logic [1:0] EV_START_LOW  = 2'd2;
    localparam logic [1:0] EV_CLEAR      = 2'd3;

    // Alarm side as a two-bit signed value.
    localparam logic [1:0] SIDE_NONE = 2'b00;
    localparam logic [1:0] SIDE_HIGH = 2'b01;
    localparam logic [1:0] SIDE_LOW  = 2'b11;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_HIGH_LIMIT      = 3'd0;
    localparam logic [2:0] REG_LOW_LIMIT       = 3'd1;
    localparam logic [2:0] REG_HYST_BELOW_HIGH = 3'd2;
    localparam logic [2:0] REG_HYST_ABOVE_LOW  = 3'd3;
    localparam logic [2:0] REG_HOLD_SECONDS    = 3'd4;
    localparam logic [2:0] REG_COUNT_REQUIRED  = 3'd5;

    // Per-channel state as stored in one memory word.
    typedef struct packed {
        logic        alarm_flag;
        logic        alarm_high_side;
        logic        exc_started;
        logic [31:0] exc_start_time;
        logic [15:0] exc_count;
        logic        ret_started;
        logic [31:0] ret_start_time;
        logic [15:0] ret_count;
        logic [31:0] start_epoch;
    } entry_t;

    typedef struct packed {
        logic [31:0] high_limit;
        logic [31:0] low_limit;
        logic [30:0] hyst_below_high;
        logic [30:0] hyst_above_low;
        logic [31:0] hold_seconds;
        logic [15:0] count_required;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  ev;
        logic [31:0] epoch;
        logic        in_alarm;
        logic [1:0]  side;
        logic        wr_en;
        logic        alarm_inc;
        logic        alarm_dec;
    } res_t;

endpackage

// ===== sv/awq_state_mem.sv =====
module awq_state_mem #(
    parameter int CHANNELS = 8,
    parameter int AW       = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  awq_pkg::entry_t wr_data,
    output awq_pkg::entry_t rd_q
);
    import awq_pkg::*;

    entry_t              mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    entry_t              rd_data_reg;
    logic                rd_valid_reg;
    logic                fwd_reg;
    entry_t              fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // An entry that was never written since reset reads as all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
                // A write to the same entry at the read edge is not yet in the
                // read data, so the written word is taken instead.
                fwd_reg      <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_comb begin
        if (fwd_reg) begin
            rd_q = fwd_data_reg;
        end else if (rd_valid_reg) begin
            rd_q = rd_data_reg;
        end else begin
            rd_q = '0;
        end
    end

endmodule

// ===== sv/awq_update.sv =====
module awq_update (
    input  logic            ch_ok,
    input  logic [31:0]     sample_value,
    input  logic [31:0]     now_seconds,
    input  awq_pkg::cfg_t   cfg,
    input  awq_pkg::entry_t cur,
    output awq_pkg::entry_t nxt,
    output awq_pkg::res_t   res
);
    import awq_pkg::*;

    typedef struct packed {
        logic        started;
        logic [31:0] t0;
        logic [15:0] cnt;
        logic        done;
    } qual_t;

    function automatic qual_t qualify(logic started, logic [31:0] t0, logic [15:0] cnt,
                                      logic [31:0] now, logic [31:0] hold,
                                      logic [15:0] req);
        qual_t       q;
        logic [31:0] elapsed;
        q.started = 1'b1;
        q.t0      = started ? t0 : now;
        q.cnt     = started ? cnt : 16'd0;
        q.done    = 1'b0;
        elapsed   = now - q.t0;
        if (elapsed >= hold) begin
            if (q.cnt < COUNT_MAX) begin
                q.cnt = q.cnt + 16'd1;
            end
            q.done = (q.cnt >= req);
        end
        return q;
    endfunction

    logic        over;
    logic        under;
    logic        norm;
    logic [33:0] v_x;
    logic [33:0] clr_high_thr;
    logic [33:0] clr_low_thr;
    qual_t       qe;
    qual_t       qr;

    assign over  = $signed(sample_value) > $signed(cfg.high_limit);
    assign under = $signed(sample_value) < $signed(cfg.low_limit);

    // Release thresholds are formed at 34 bits so they never wrap.
    assign v_x          = {{2{sample_value[31]}}, sample_value};
    assign clr_high_thr = {{2{cfg.high_limit[31]}}, cfg.high_limit}
                          - {3'b000, cfg.hyst_below_high};
    assign clr_low_thr  = {{2{cfg.low_limit[31]}}, cfg.low_limit}
                          + {3'b000, cfg.hyst_above_low};
    assign norm = cur.alarm_high_side ? ($signed(v_x) <= $signed(clr_high_thr))
                                      : ($signed(v_x) >= $signed(clr_low_thr));

    assign qe = qualify(cur.exc_started, cur.exc_start_time, cur.exc_count,
                        now_seconds, cfg.hold_seconds, cfg.count_required);
    assign qr = qualify(cur.ret_started, cur.ret_start_time, cur.ret_count,
                        now_seconds, cfg.hold_seconds, cfg.count_required);

    always_comb begin
        nxt           = cur;
        res.ev        = EV_NONE;
        res.epoch     = 32'd0;
        res.wr_en     = ch_ok;
        res.alarm_inc = 1'b0;
        res.alarm_dec = 1'b0;
        if (!cur.alarm_flag) begin
            if (over || under) begin
                nxt.exc_started    = qe.started;
                nxt.exc_start_time = qe.t0;
                nxt.exc_count      = qe.cnt;
                if (qe.done) begin
                    nxt.alarm_flag      = 1'b1;
                    nxt.alarm_high_side = over;
                    nxt.ret_started     = 1'b0;
                    nxt.ret_count       = 16'd0;
                    nxt.start_epoch     = now_seconds;
                    res.alarm_inc       = ch_ok;
                    res.ev              = over ? EV_START_HIGH : EV_START_LOW;
                    res.epoch           = now_seconds;
                end
            end else begin
                nxt.exc_started = 1'b0;
                nxt.exc_count   = 16'd0;
            end
        end else begin
            if (norm) begin
                nxt.ret_started    = qr.started;
                nxt.ret_start_time = qr.t0;
                nxt.ret_count      = qr.cnt;
                if (qr.done) begin
                    nxt           = '0;
                    res.ev        = EV_CLEAR;
                    res.epoch     = cur.start_epoch;
                    res.alarm_dec = ch_ok;
                end
            end else begin
                nxt.ret_started = 1'b0;
                nxt.ret_count   = 16'd0;
            end
        end
        res.in_alarm = nxt.alarm_flag;
        if (!nxt.alarm_flag) begin
            res.side = SIDE_NONE;
        end else if (nxt.alarm_high_side) begin
            res.side = SIDE_HIGH;
        end else begin
            res.side = SIDE_LOW;
        end
        // A channel outside the configured range leaves everything untouched.
        if (!ch_ok) begin
            res.ev       = EV_NONE;
            res.epoch    = 32'd0;
            res.in_alarm = 1'b0;
            res.side     = SIDE_NONE;
        end
    end

endmodule

// ===== sv/analog_window_alarm_qualifier.sv =====
// Window alarm qualifier for up to CHANNELS analog channels.
//
// Input stream: s_tuser carries the channel index, s_tdata the sample value
// and its timestamp in seconds. Output stream: m_tuser carries the channel,
// m_tdata the event code, event epoch, alarm state, alarm side and the
// any-alarm flag. Every input transaction yields exactly one output
// transaction, in order.
//
// Throughput is one transaction per cycle while the receiver does not stall. A
// sample is registered together with the read of its channel's state word; the
// compute stage then computes the update and writes it back while loading the
// output register. A sample for the channel just updated takes the written
// word by forwarding.
//
// Reset clears all channel state, the alarm count and the configuration
// registers to their defaults. When the receiver stalls, the output register
// holds its result, one more sample waits in the compute stage, and s_tready
// falls until the output drains. Registers are written over the APB port.
module analog_window_alarm_qualifier #(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] sample_value, [63:32] now_seconds
    input  logic [2:0]  s_tuser,    // [2:0] channel
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [1:0] event_res, [33:2] event_epoch,
                                    // [34] in_alarm_out, [36:35] side_out,
                                    // [37] any_alarm, [39:38] zero
    output logic [2:0]  m_tuser,    // [2:0] channel_out
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import awq_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;

    logic        s1_valid_reg;
    logic [2:0]  s1_ch_reg;
    logic [31:0] s1_value_reg;
    logic [31:0] s1_now_reg;
    logic        s1_adv;
    logic        in_acc;
    logic        ch_ok;

    entry_t      cur;
    entry_t      nxt;
    res_t        res;

    logic [CW-1:0] alarm_cnt_reg;
    logic [CW-1:0] alarm_cnt_next;

    logic        m_valid_reg;
    logic [2:0]  m_ch_reg;
    logic [1:0]  m_ev_reg;
    logic [31:0] m_epoch_reg;
    logic        m_in_alarm_reg;
    logic [1:0]  m_side_reg;
    logic        m_any_reg;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_limit      <= 32'h7FFF_FFFF;
            cfg_reg.low_limit       <= 32'h8000_0000;
            cfg_reg.hyst_below_high <= 31'd0;
            cfg_reg.hyst_above_low  <= 31'd0;
            cfg_reg.hold_seconds    <= 32'd0;
            cfg_reg.count_required  <= 16'd1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HIGH_LIMIT:      cfg_reg.high_limit      <= pwdata;
                REG_LOW_LIMIT:       cfg_reg.low_limit       <= pwdata;
                REG_HYST_BELOW_HIGH: cfg_reg.hyst_below_high <= pwdata[30:0];
                REG_HYST_ABOVE_LOW:  cfg_reg.hyst_above_low  <= pwdata[30:0];
                REG_HOLD_SECONDS:    cfg_reg.hold_seconds    <= pwdata;
                REG_COUNT_REQUIRED:  cfg_reg.count_required  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HIGH_LIMIT:      prdata = cfg_reg.high_limit;
            REG_LOW_LIMIT:       prdata = cfg_reg.low_limit;
            REG_HYST_BELOW_HIGH: prdata = {1'b0, cfg_reg.hyst_below_high};
            REG_HYST_ABOVE_LOW:  prdata = {1'b0, cfg_reg.hyst_above_low};
            REG_HOLD_SECONDS:    prdata = cfg_reg.hold_seconds;
            REG_COUNT_REQUIRED:  prdata = {16'd0, cfg_reg.count_required};
            default:             prdata = 32'd0;
        endcase
    end

    // Handshake and compute stage
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;
    assign ch_ok    = {29'd0, s1_ch_reg} < 32'(CHANNELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_ch_reg    <= s_tuser;
            s1_value_reg <= s_tdata[31:0];
            s1_now_reg   <= s_tdata[63:32];
        end
    end

    awq_state_mem #(
        .CHANNELS(CHANNELS),
        .AW      (AW)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_en  (in_acc),
        .rd_addr(AW'(s_tuser)),
        .wr_en  (s1_adv && res.wr_en),
        .wr_addr(AW'(s1_ch_reg)),
        .wr_data(nxt),
        .rd_q   (cur)
    );

    awq_update u_update (
        .ch_ok       (ch_ok),
        .sample_value(s1_value_reg),
        .now_seconds (s1_now_reg),
        .cfg         (cfg_reg),
        .cur         (cur),
        .nxt         (nxt),
        .res         (res)
    );

    always_comb begin
        alarm_cnt_next = alarm_cnt_reg;
        if (res.alarm_inc) begin
            alarm_cnt_next = alarm_cnt_reg + CW'(1);
        end else if (res.alarm_dec && (alarm_cnt_reg != '0)) begin
            alarm_cnt_next = alarm_cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_cnt_reg <= '0;
        end else if (s1_adv) begin
            alarm_cnt_reg <= alarm_cnt_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_ch_reg       <= s1_ch_reg;
            m_ev_reg       <= res.ev;
            m_epoch_reg    <= res.epoch;
            m_in_alarm_reg <= res.in_alarm;
            m_side_reg     <= res.side;
            m_any_reg      <= (alarm_cnt_next != '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ch_reg;
    assign m_tdata  = {2'b00, m_any_reg, m_side_reg, m_in_alarm_reg, m_epoch_reg, m_ev_reg};

    // Checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {{(32-CW){1'b0}}, alarm_cnt_reg} <= 32'(CHANNELS))
        else $error("alarm count exceeds channel count");

    a_clear_not_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_ev_reg == EV_CLEAR))
        |-> (!m_in_alarm_reg && (m_side_reg == SIDE_NONE)))
        else $error("cleared result still reports an alarm");

    a_alarm_any: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_in_alarm_reg) |-> m_any_reg)
        else $error("channel in alarm but any-alarm flag low");

    a_start_in_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ((m_ev_reg == EV_START_HIGH) || (m_ev_reg == EV_START_LOW)))
        |-> m_in_alarm_reg)
        else $error("alarm start without alarm state");

    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

endmodule

// ===== verif/tb_analog_window_alarm_qualifier.sv =====
module tb_analog_window_alarm_qualifier;
    timeunit 1ns;
    timeprecision 1ps;

    import awq_pkg::*;

    localparam int     LONG_HOLD = 400;
    localparam longint S32_MAX   = 64'sh7FFF_FFFF;
    localparam longint S32_MIN   = -64'sh8000_0000;

    typedef struct packed {
        logic [2:0]  chan;
        logic [31:0] value;
        logic [31:0] stamp;
    } sample_t;

    typedef struct packed {
        logic [2:0]  chan;
        logic [1:0]  ev;
        logic [31:0] epoch;
        logic        in_alarm;
        logic [1:0]  side;
        logic        any_alarm;
    } alarm_report_t;

    typedef enum int {V_OVER, V_UNDER, V_CALM, V_BAND, V_EDGE} value_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block's registers and per-channel state.
    cfg_t        cfg_shadow;
    entry_t      chan_state [8];
    int unsigned alarms_active;

    sample_t       sample_q [$];
    alarm_report_t report_q [$];
    logic [31:0]   chan_clock [8];

    int unsigned issued_total, accepted_total, checked_total, mismatches;
    int unsigned starts_predicted, clears_predicted, settings_applied, input_stall_cycles;
    int unsigned send_gap, ready_gap;
    bit          idle_on, long_hold_req, long_hold_done;
    alarm_report_t got_report, want_report;

    analog_window_alarm_qualifier u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic string show(input alarm_report_t r);
        return $sformatf("ch %0d ev %0d epoch %h alarm %0b side %b any %0b",
                         r.chan, r.ev, r.epoch, r.in_alarm, r.side, r.any_alarm);
    endfunction

    task automatic note_failure(input string text);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t  %s", $time, text);
        end
    endtask

    // Hold timer and sample counter shared by the alarm and the return path.
    function automatic logic run_timer(inout logic started, inout logic [31:0] t0,
                                       inout logic [15:0] cnt, input logic [31:0] now);
        logic [31:0] waited;
        if (!started) begin
            started = 1'b1;
            t0      = now;
            cnt     = '0;
        end
        waited = now - t0;
        if (waited >= cfg_shadow.hold_seconds) begin
            if (cnt < COUNT_MAX) begin
                cnt = cnt + 16'd1;
            end
            return cnt >= cfg_shadow.count_required;
        end
        return 1'b0;
    endfunction

    function automatic alarm_report_t judge_sample(input sample_t smp);
        entry_t        e;
        alarm_report_t rep;
        longint        v, hi, lo;
        logic          over, under, back;
        e   = chan_state[smp.chan];
        v   = longint'($signed(smp.value));
        hi  = longint'($signed(cfg_shadow.high_limit));
        lo  = longint'($signed(cfg_shadow.low_limit));
        rep = '0;
        rep.chan = smp.chan;
        rep.ev   = EV_NONE;
        if (!e.alarm_flag) begin
            over  = v > hi;
            under = v < lo;
            if (over || under) begin
                if (run_timer(e.exc_started, e.exc_start_time, e.exc_count, smp.stamp)) begin
                    e.alarm_flag      = 1'b1;
                    e.alarm_high_side = over;
                    e.ret_started     = 1'b0;
                    e.ret_count       = '0;
                    e.start_epoch     = smp.stamp;
                    alarms_active++;
                    starts_predicted++;
                    rep.ev    = over ? EV_START_HIGH : EV_START_LOW;
                    rep.epoch = smp.stamp;
                end
            end else begin
                e.exc_started = 1'b0;
                e.exc_count   = '0;
            end
        end else begin
            // The hysteresis points are computed wide so they never wrap.
            back = e.alarm_high_side
                 ? (v <= hi - longint'(cfg_shadow.hyst_below_high))
                 : (v >= lo + longint'(cfg_shadow.hyst_above_low));
            if (back) begin
                if (run_timer(e.ret_started, e.ret_start_time, e.ret_count, smp.stamp)) begin
                    rep.ev    = EV_CLEAR;
                    rep.epoch = e.start_epoch;
                    e         = '0;
                    clears_predicted++;
                    if (alarms_active > 0) begin
                        alarms_active--;
                    end
                end
            end else begin
                e.ret_started = 1'b0;
                e.ret_count   = '0;
            end
        end
        chan_state[smp.chan] = e;
        rep.in_alarm  = e.alarm_flag;
        rep.side      = !e.alarm_flag ? SIDE_NONE : (e.alarm_high_side ? SIDE_HIGH : SIDE_LOW);
        rep.any_alarm = alarms_active != 0;
        return rep;
    endfunction

    // Sample values aimed at the current limits and hysteresis points.
    function automatic logic [31:0] pick_value(input value_kind_t kind);
        longint     hi, lo, up, dn, x;
        logic [63:0] r;
        hi = longint'($signed(cfg_shadow.high_limit));
        lo = longint'($signed(cfg_shadow.low_limit));
        up = hi - longint'(cfg_shadow.hyst_below_high);
        dn = lo + longint'(cfg_shadow.hyst_above_low);
        r  = {$urandom, $urandom};
        case (kind)
            V_OVER:  x = hi + 1 + longint'(r[17:0]);
            V_UNDER: x = lo - 1 - longint'(r[17:0]);
            V_CALM: begin
                if (dn <= up) begin
                    x = dn + longint'(r[62:0]) % (up - dn + 1);
                end else begin
                    x = r[0] ? up : dn;
                end
            end
            V_BAND: begin
                if (r[63]) begin
                    x = hi - longint'(r[30:0]) % (longint'(cfg_shadow.hyst_below_high) + 1);
                end else begin
                    x = lo + longint'(r[30:0]) % (longint'(cfg_shadow.hyst_above_low) + 1);
                end
            end
            default: begin
                case ($urandom_range(0, 9))
                    0:       x = hi;
                    1:       x = hi + 1;
                    2:       x = lo;
                    3:       x = lo - 1;
                    4:       x = up;
                    5:       x = up + 1;
                    6:       x = dn;
                    7:       x = dn - 1;
                    8:       x = S32_MAX;
                    default: x = S32_MIN;
                endcase
            end
        endcase
        if (x > S32_MAX) begin
            x = S32_MAX;
        end
        if (x < S32_MIN) begin
            x = S32_MIN;
        end
        return x[31:0];
    endfunction

    task automatic push_sample(input logic [2:0] ch, input logic [31:0] val,
                               input logic [31:0] stamp);
        sample_q.push_back('{chan: ch, value: val, stamp: stamp});
        issued_total++;
    endtask

    task automatic wait_drained();
        while (accepted_total != issued_total || checked_total != accepted_total) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_register(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] want;
        case (idx)
            REG_HIGH_LIMIT:      cfg_shadow.high_limit      = data;
            REG_LOW_LIMIT:       cfg_shadow.low_limit       = data;
            REG_HYST_BELOW_HIGH: cfg_shadow.hyst_below_high = data[30:0];
            REG_HYST_ABOVE_LOW:  cfg_shadow.hyst_above_low  = data[30:0];
            REG_HOLD_SECONDS:    cfg_shadow.hold_seconds    = data;
            default:             cfg_shadow.count_required  = data[15:0];
        endcase
        case (idx)
            REG_HIGH_LIMIT:      want = cfg_shadow.high_limit;
            REG_LOW_LIMIT:       want = cfg_shadow.low_limit;
            REG_HYST_BELOW_HIGH: want = {1'b0, cfg_shadow.hyst_below_high};
            REG_HYST_ABOVE_LOW:  want = {1'b0, cfg_shadow.hyst_above_low};
            REG_HOLD_SECONDS:    want = cfg_shadow.hold_seconds;
            default:             want = {16'd0, cfg_shadow.count_required};
        endcase
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Read the register back through a second transfer.
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            note_failure($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] hi, input logic [31:0] lo,
                                 input logic [31:0] hyst_hi, input logic [31:0] hyst_lo,
                                 input logic [31:0] hold, input logic [31:0] need);
        wait_drained();
        program_register(REG_HIGH_LIMIT, hi);
        program_register(REG_LOW_LIMIT, lo);
        program_register(REG_HYST_BELOW_HIGH, hyst_hi);
        program_register(REG_HYST_ABOVE_LOW, hyst_lo);
        program_register(REG_HOLD_SECONDS, hold);
        program_register(REG_COUNT_REQUIRED, need);
        settings_applied++;
    endtask

    task automatic apply_random_setting();
        int base, low;
        base = int'($urandom_range(0, 2_000_000)) - 1_000_000;
        // Now and then the low limit sits above the high one.
        if ($urandom_range(0, 7) == 0) begin
            low = base + int'($urandom_range(1, 200_000));
        end else begin
            low = base - int'($urandom_range(0, 500_000));
        end
        apply_setting(base, low,
                      ($urandom_range(0, 7) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 300_000),
                      ($urandom_range(0, 7) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 300_000),
                      $urandom_range(0, 4), $urandom_range(0, 5));
    endtask

    // Mostly runs of samples on one channel with a common trend, some noise.
    task automatic fill_random(input int n);
        int          made, len;
        value_kind_t kind;
        logic [2:0]  ch;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 4) == 0) begin
                push_sample(3'($urandom), $urandom, $urandom);
                made++;
            end else begin
                ch   = 3'($urandom_range(0, 7));
                kind = value_kind_t'($urandom_range(0, 3));
                len  = $urandom_range(2, 10);
                repeat (len) begin
                    chan_clock[ch] += ($urandom_range(0, 3) == 0)
                                    ? cfg_shadow.hold_seconds + $urandom_range(0, 2)
                                    : $urandom_range(0, 2);
                    push_sample(ch, pick_value(($urandom_range(0, 5) == 0) ? V_EDGE : kind),
                                chan_clock[ch]);
                    made++;
                end
            end
        end
    endtask

    // Sender: one transaction at a time from the sample queue.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                report_q.push_back(judge_sample('{chan: s_tuser, value: s_tdata[31:0],
                                                  stamp: s_tdata[63:32]}));
                accepted_total++;
            end
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= sample_q[0].chan;
                    s_tdata  <= {sample_q[0].stamp, sample_q[0].value};
                    void'(sample_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            ready_gap      <= LONG_HOLD;
            m_tready       <= 1'b0;
        end else if (ready_gap > 1) begin
            ready_gap <= ready_gap - 1;
            m_tready  <= 1'b0;
        end else if (ready_gap == 1) begin
            ready_gap <= 0;
            m_tready  <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_gap <= $urandom_range(1, 17);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Checker: every result transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_report.chan      = m_tuser;
            got_report.ev        = m_tdata[1:0];
            got_report.epoch     = m_tdata[33:2];
            got_report.in_alarm  = m_tdata[34];
            got_report.side      = m_tdata[36:35];
            got_report.any_alarm = m_tdata[37];
            if (report_q.size() == 0) begin
                note_failure({"result with nothing pending: ", show(got_report)});
            end else begin
                want_report = report_q.pop_front();
                checked_total++;
                if (got_report.chan !== want_report.chan || got_report.ev !== want_report.ev
                    || got_report.epoch !== want_report.epoch
                    || got_report.in_alarm !== want_report.in_alarm
                    || got_report.side !== want_report.side
                    || got_report.any_alarm !== want_report.any_alarm) begin
                    note_failure({"expected ", show(want_report), ", got ", show(got_report)});
                end
            end
        end
    end

    initial begin
        cfg_shadow = '{high_limit: 32'h7FFF_FFFF, low_limit: 32'h8000_0000,
                       hyst_below_high: '0, hyst_above_low: '0,
                       hold_seconds: '0, count_required: 16'd1};
        for (int i = 0; i < 8; i++) begin
            chan_state[i] = '0;
            chan_clock[i] = $urandom;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Limits at +/-100.0, hysteresis 10.0, no hold, one sample to qualify.
        apply_setting(32'h0064_0000, 32'hFF9C_0000, 32'h000A_0000, 32'h000A_0000, 0, 1);
        push_sample(3'd0, 32'h7FFF_FFFF, 32'h0000_0000);
        push_sample(3'd0, 32'h005A_0001, 32'h0000_0001);
        push_sample(3'd0, 32'h005A_0000, 32'h0000_0002);
        push_sample(3'd7, 32'h8000_0000, 32'hFFFF_FFFF);
        push_sample(3'd7, 32'hFFA6_0000, 32'h0000_0000);
        push_sample(3'd3, 32'h0064_0000, 32'h0000_0005);
        push_sample(3'd3, 32'h0064_0001, 32'h0000_0006);
        push_sample(3'd5, 32'hFF9B_FFFF, 32'h0000_0007);
        push_sample(3'd3, 32'h0000_0000, 32'h0000_0008);
        push_sample(3'd5, 32'h0000_0000, 32'h0000_0009);
        push_sample(3'd2, 32'h5555_5555, 32'hAAAA_AAAA);
        push_sample(3'd4, 32'hAAAA_AAAA, 32'h5555_5555);
        push_sample(3'd1, 32'h0000_0000, 32'h0000_0000);

        // High limit below the low one, hold of two seconds, zero count needed.
        apply_setting(32'hFFFB_0000, 32'h0005_0000, 0, 0, 2, 0);
        push_sample(3'd6, 32'h0000_0000, 32'd100);
        push_sample(3'd6, 32'h0000_0000, 32'd101);
        push_sample(3'd6, 32'h0000_0000, 32'd102);
        push_sample(3'd6, 32'hFFFB_0000, 32'd200);
        push_sample(3'd6, 32'hFFFB_0000, 32'd50);
        push_sample(3'd1, 32'h0009_0000, 32'd10);
        push_sample(3'd1, 32'h0009_0000, 32'd5);

        idle_on = 1'b1;
        apply_random_setting();
        fill_random(200);
        long_hold_req = 1'b1;

        // Every value but the extremes is over and under at once, clearing is out of reach.
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        fill_random(150);

        apply_random_setting();
        fill_random(200);

        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 32'h0000_FFFF);
        fill_random(100);

        apply_random_setting();
        fill_random(200);

        idle_on = 1'b0;
        apply_random_setting();
        fill_random(300);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (report_q.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", report_q.size()));
        end
        $display("Checked %0d samples under %0d register settings, %0d failures.",
                 checked_total, settings_applied, mismatches);
        $display("Predicted %0d alarm starts and %0d clears; input held off %0d cycles.",
                 starts_predicted, clears_predicted, input_stall_cycles);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
